[design/deadline_timer_queue_with_leases_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the deadline timer queue.
// Each macro expands to a labeled concurrent assertion, or to nothing.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_WITH_LEASES_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_WITH_LEASES_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked at every clock edge, off during reset.
`define DTQ_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Implication whose consequent is checked at the next clock edge.
`define DTQ_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define DTQ_ASSERT_IMP(label, clk, rst, a, c)
`define DTQ_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[design/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants for the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int TIME_BITS   = 48;
  localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_BITS   = 5;
  localparam int CAP_BITS    = 5;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic [2:0] {
    CMD_SCHEDULE = 3'd0,
    CMD_RESERVE  = 3'd1,
    CMD_ARM      = 3'd2,
    CMD_CANCEL   = 3'd3,
    CMD_RELEASE  = 3'd4,
    CMD_TICK     = 3'd5,
    CMD_STOP     = 3'd6,
    CMD_UNUSED   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_FIND,
    ST_SHIFT,
    ST_FIRE,
    ST_ACK
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] delay_ms;
    logic [15:0] task_tag;
    logic [4:0]  lease_slot;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic        ok;
    logic [4:0]  lease_out;
    logic [15:0] tag_out;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [TAG_BITS-1:0]  tag;
    logic [SLOT_BITS-1:0] owner;
  } entry_t;

endpackage

[design/deadline_timer_queue_with_leases.sv]
// ----------------------------------------------------------------------------
// deadline_timer_queue_with_leases
// Bounded timer queue sorted by deadline, with lease slots.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Results appear
// one per cycle on result, marked by result_valid; they cannot be stalled.
// One sequencer walks the entry array one entry a cycle and stays busy until
// a word is done, so it takes no new word before then: dropping a lease task
// walks all entries, a sorted insert walks to the insert point and then
// shifts the tail, and a tick fires one entry a cycle.
module deadline_timer_queue_with_leases (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  dtq_pkg::in_word_t  cmd_in,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  output logic               result_valid,
  output dtq_pkg::out_word_t result
);

  // Registers.
  dtq_pkg::state_t state, state_next;
  dtq_pkg::entry_t ent [dtq_pkg::QUEUE_DEPTH];
  logic [dtq_pkg::CNT_BITS-1:0] count, count_next;
  logic [dtq_pkg::CNT_BITS-1:0] unres, unres_next;
  logic [dtq_pkg::QUEUE_DEPTH-1:0] lease_use, lease_use_next;
  logic [dtq_pkg::TIME_BITS-1:0] now, now_next;
  logic stopping, stopping_next;
  logic [4:0] cap;
  dtq_pkg::in_word_t req;
  logic [dtq_pkg::TIME_BITS-1:0] dl, dl_next;
  logic [dtq_pkg::CNT_BITS-1:0] rd, rd_next, wr, wr_next;
  logic ok, ok_next;
  logic [4:0] grant, grant_next;
  logic fired, fired_next;

  // Entry write port driven by the sequencer.
  logic ent_we;
  logic [dtq_pkg::IDX_BITS-1:0] ent_wa;
  dtq_pkg::entry_t ent_wd;

  // Combinational helpers.
  logic [dtq_pkg::CNT_BITS:0] used;
  logic [dtq_pkg::CNT_BITS-1:0] held;
  logic [dtq_pkg::CNT_BITS-1:0] cap_eff;
  logic room, slot_ok;
  logic [dtq_pkg::TIME_BITS:0] sum;
  logic [dtq_pkg::TIME_BITS-1:0] dl_new;
  logic [4:0] free_slot;
  logic free_any;
  dtq_pkg::entry_t cur;
  logic [dtq_pkg::IDX_BITS-1:0] rd_idx;

  assign rd_idx = rd[dtq_pkg::IDX_BITS-1:0];
  assign cur = ent[rd_idx];
  assign busy = (state != dtq_pkg::ST_IDLE);

  always_comb begin
    held = '0;
    free_slot = '0;
    free_any = 1'b0;
    for (int i = dtq_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
      held = held + dtq_pkg::CNT_BITS'(lease_use[i]);
      if (!lease_use[i]) begin
        free_slot = 5'(i + 1);
        free_any = 1'b1;
      end
    end
  end

  assign cap_eff = (cap > 5'(dtq_pkg::QUEUE_DEPTH)) ? dtq_pkg::CNT_BITS'(dtq_pkg::QUEUE_DEPTH)
                                                     : dtq_pkg::CNT_BITS'(cap);
  assign used = {1'b0, unres} + {1'b0, held};
  assign room = used < {1'b0, cap_eff};
  assign slot_ok = (cmd_in.lease_slot >= 5'd1) &&
                   (cmd_in.lease_slot <= 5'(dtq_pkg::QUEUE_DEPTH)) &&
                   lease_use[4'(cmd_in.lease_slot - 5'd1)];
  assign sum = {1'b0, now} + {17'b0, cmd_in.delay_ms};
  assign dl_new = sum[dtq_pkg::TIME_BITS] ? dtq_pkg::TIME_MAX : sum[dtq_pkg::TIME_BITS-1:0];

  // State register and controls.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtq_pkg::ST_IDLE;
      count <= '0;
      unres <= '0;
      lease_use <= '0;
      now <= '0;
      stopping <= 1'b0;
      cap <= 5'd16;
    end else begin
      state <= state_next;
      count <= count_next;
      unres <= unres_next;
      lease_use <= lease_use_next;
      now <= now_next;
      stopping <= stopping_next;
      if (cfg_we) cap <= cfg_data;
    end
  end

  // Working registers and entry array.
  always_ff @(posedge clk) begin
    if (start && !busy) req <= cmd_in;
    dl <= dl_next;
    rd <= rd_next;
    wr <= wr_next;
    ok <= ok_next;
    grant <= grant_next;
    fired <= fired_next;
    if (ent_we) ent[ent_wa] <= ent_wd;
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    count_next = count;
    unres_next = unres;
    lease_use_next = lease_use;
    now_next = now;
    stopping_next = stopping;
    dl_next = dl;
    rd_next = rd;
    wr_next = wr;
    ok_next = ok;
    grant_next = grant;
    fired_next = fired;
    ent_we = 1'b0;
    ent_wa = rd_idx;
    ent_wd = cur;
    result_valid = 1'b0;
    result = '0;
    case (state)
      dtq_pkg::ST_IDLE: begin
        if (start) begin
          ok_next = 1'b0;
          grant_next = '0;
          fired_next = 1'b0;
          rd_next = '0;
          wr_next = '0;
          dl_next = dl_new;
          state_next = dtq_pkg::ST_ACK;
          case (cmd_in.cmd)
            dtq_pkg::CMD_SCHEDULE: begin
              if (!stopping && room && count < dtq_pkg::CNT_BITS'(dtq_pkg::QUEUE_DEPTH))
                state_next = dtq_pkg::ST_FIND;
            end
            dtq_pkg::CMD_RESERVE: begin
              if (!stopping && room && free_any) begin
                lease_use_next[4'(free_slot - 5'd1)] = 1'b1;
                grant_next = free_slot;
                ok_next = 1'b1;
              end
            end
            dtq_pkg::CMD_ARM, dtq_pkg::CMD_CANCEL, dtq_pkg::CMD_RELEASE: begin
              if (!stopping && slot_ok) state_next = dtq_pkg::ST_DROP;
            end
            dtq_pkg::CMD_TICK: begin
              if (!stopping) begin
                ok_next = 1'b1;
                if (now != dtq_pkg::TIME_MAX) now_next = now + 1'b1;
                state_next = dtq_pkg::ST_FIRE;
              end
            end
            dtq_pkg::CMD_STOP: begin
              stopping_next = 1'b1;
              count_next = '0;
              unres_next = '0;
              ok_next = 1'b1;
            end
            default: ;
          endcase
        end
      end
      // Compact out the entries owned by the lease, one per cycle.
      dtq_pkg::ST_DROP: begin
        if (rd == count) begin
          count_next = wr;
          rd_next = '0;
          if (req.cmd == dtq_pkg::CMD_ARM) begin
            state_next = dtq_pkg::ST_FIND;
          end else begin
            if (req.cmd == dtq_pkg::CMD_RELEASE)
              lease_use_next[4'(req.lease_slot - 5'd1)] = 1'b0;
            ok_next = 1'b1;
            state_next = dtq_pkg::ST_ACK;
          end
        end else begin
          if (cur.owner != req.lease_slot) begin
            ent_we = 1'b1;
            ent_wa = wr[dtq_pkg::IDX_BITS-1:0];
            wr_next = wr + 1'b1;
          end
          rd_next = rd + 1'b1;
        end
      end
      // Walk to the insert point.
      dtq_pkg::ST_FIND: begin
        if (rd != count && cur.deadline <= dl) begin
          rd_next = rd + 1'b1;
        end else begin
          wr_next = count;
          state_next = dtq_pkg::ST_SHIFT;
        end
      end
      // Shift the tail up one place, then write the new entry.
      dtq_pkg::ST_SHIFT: begin
        ent_we = 1'b1;
        if (wr == rd) begin
          ent_wa = rd_idx;
          ent_wd.deadline = dl;
          ent_wd.tag = req.task_tag;
          ent_wd.owner = (req.cmd == dtq_pkg::CMD_ARM) ? req.lease_slot : 5'd0;
          count_next = count + 1'b1;
          if (req.cmd != dtq_pkg::CMD_ARM) unres_next = unres + 1'b1;
          ok_next = 1'b1;
          state_next = dtq_pkg::ST_ACK;
        end else begin
          ent_wa = wr[dtq_pkg::IDX_BITS-1:0];
          ent_wd = ent[4'(wr - 1'b1)];
          wr_next = wr - 1'b1;
        end
      end
      // Fire due entries from the head, then compact the rest down.
      dtq_pkg::ST_FIRE: begin
        if (rd != count && !fired && cur.deadline <= now) begin
          result_valid = 1'b1;
          result.kind = 1'b1;
          result.ok = 1'b1;
          result.lease_out = cur.owner;
          result.tag_out = cur.tag;
          rd_next = rd + 1'b1;
          if (cur.owner == 5'd0 && unres != '0) unres_next = unres - 1'b1;
          result.last = !((rd + 1'b1) != count && ent[4'(rd + 1'b1)].deadline <= now);
          if (result.last) fired_next = 1'b1;
        end else if (rd != count) begin
          ent_we = 1'b1;
          ent_wa = wr[dtq_pkg::IDX_BITS-1:0];
          wr_next = wr + 1'b1;
          rd_next = rd + 1'b1;
          fired_next = 1'b1;
        end else begin
          count_next = wr;
          if (rd != wr) state_next = dtq_pkg::ST_IDLE;
          else state_next = dtq_pkg::ST_ACK;
        end
      end
      dtq_pkg::ST_ACK: begin
        result_valid = 1'b1;
        result.ok = ok;
        result.lease_out = grant;
        result.last = 1'b1;
        state_next = dtq_pkg::ST_IDLE;
      end
      default: state_next = dtq_pkg::ST_IDLE;
    endcase
  end

`include "deadline_timer_queue_with_leases_macros.svh"
  // The queue never grows beyond its depth.
  `DTQ_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= dtq_pkg::CNT_BITS'(dtq_pkg::QUEUE_DEPTH))
  // Every result closes or continues a command in progress.
  `DTQ_ASSERT_IMP(a_result_busy, clk, rst, result_valid, busy)
  // Taking a command makes the block busy.
  `DTQ_ASSERT_NEXT(a_take_busy, clk, rst, start && !busy, busy)
  // Once stopped, the block stays stopped.
  `DTQ_ASSERT_NEXT(a_stop_holds, clk, rst, stopping, stopping)

endmodule

[dv/dtq_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer queue checker
// Watches the command and result channels of the deadline timer queue, keeps
// its own model of the queue, leases and time, and compares every result word.
// ----------------------------------------------------------------------------
module dtq_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  dtq_pkg::in_word_t  cmd_in,
  input  logic               busy,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  logic               result_valid,
  input  dtq_pkg::out_word_t result,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct {
    logic [dtq_pkg::TIME_BITS-1:0] deadline;
    logic [15:0]                   tag;
    logic [4:0]                    owner;
  } timer_t;

  timer_t                        timers[$];
  logic [4:0]                    capacity;
  logic [15:0]                   lease_held;
  int                            loose_tasks;
  logic [dtq_pkg::TIME_BITS-1:0] now_ms;
  logic                          halted;
  dtq_pkg::out_word_t            expected_words[$];

  function automatic dtq_pkg::out_word_t make_word(logic k, logic okv, logic [4:0] l,
                                                   logic [15:0] t, logic lst);
    dtq_pkg::out_word_t w;
    w.kind = k; w.ok = okv; w.lease_out = l; w.tag_out = t; w.last = lst;
    return w;
  endfunction

  function automatic bit room_left();
    int cap;
    cap = (capacity > dtq_pkg::QUEUE_DEPTH) ? dtq_pkg::QUEUE_DEPTH : capacity;
    return (loose_tasks + $countones(lease_held)) < cap;
  endfunction

  function automatic void drop_lease_timers(logic [4:0] slot);
    timer_t kept[$];
    foreach (timers[i]) if (timers[i].owner != slot) kept.push_back(timers[i]);
    timers = kept;
  endfunction

  function automatic bit add_timer(logic [31:0] delay, logic [15:0] tag,
                                   logic [4:0] owner);
    logic [dtq_pkg::TIME_BITS:0] sum;
    timer_t t;
    int pos;
    if (timers.size() >= dtq_pkg::QUEUE_DEPTH) return 0;
    sum = {1'b0, now_ms} + delay;
    t.deadline = sum[dtq_pkg::TIME_BITS] ? dtq_pkg::TIME_MAX
                                         : sum[dtq_pkg::TIME_BITS-1:0];
    t.tag = tag;
    t.owner = owner;
    pos = 0;
    while (pos < timers.size() && timers[pos].deadline <= t.deadline) pos++;
    timers.insert(pos, t);
    return 1;
  endfunction

  function automatic bit lease_valid(logic [4:0] slot);
    return slot >= 1 && slot <= dtq_pkg::QUEUE_DEPTH && lease_held[slot-1];
  endfunction

  // Apply one accepted command word and queue its expected results.
  function automatic void predict_command(dtq_pkg::in_word_t w);
    logic       okv;
    logic [4:0] grant;
    int         fired;
    okv = 0; grant = 0; fired = 0;
    case (w.cmd)
      dtq_pkg::CMD_SCHEDULE: begin
        okv = !halted && room_left() && add_timer(w.delay_ms, w.task_tag, 0);
        if (okv) loose_tasks++;
      end
      dtq_pkg::CMD_RESERVE: begin
        if (!halted && room_left()) begin
          for (int i = 0; i < dtq_pkg::QUEUE_DEPTH; i++) begin
            if (!lease_held[i] && !okv) begin
              lease_held[i] = 1'b1;
              grant = 5'(i + 1);
              okv = 1;
            end
          end
        end
      end
      dtq_pkg::CMD_ARM: begin
        if (!halted && lease_valid(w.lease_slot)) begin
          drop_lease_timers(w.lease_slot);
          okv = add_timer(w.delay_ms, w.task_tag, w.lease_slot);
        end
      end
      dtq_pkg::CMD_CANCEL, dtq_pkg::CMD_RELEASE: begin
        if (!halted && lease_valid(w.lease_slot)) begin
          drop_lease_timers(w.lease_slot);
          if (w.cmd == dtq_pkg::CMD_RELEASE) lease_held[w.lease_slot-1] = 1'b0;
          okv = 1;
        end
      end
      dtq_pkg::CMD_TICK: begin
        if (!halted) begin
          if (now_ms != dtq_pkg::TIME_MAX) now_ms++;
          while (timers.size() > 0 && timers[0].deadline <= now_ms) begin
            expected_words.push_back(make_word(1, 1, timers[0].owner,
                                               timers[0].tag, 0));
            if (timers[0].owner == 0 && loose_tasks > 0) loose_tasks--;
            void'(timers.pop_front());
            fired++;
          end
          if (fired > 0) expected_words[$].last = 1'b1;
          else okv = 1;
        end
      end
      dtq_pkg::CMD_STOP: begin
        halted = 1;
        timers.delete();
        loose_tasks = 0;
        okv = 1;
      end
      default: ;
    endcase
    if (fired == 0) expected_words.push_back(make_word(0, okv, grant, 0, 1));
  endfunction

  // Sample both channels at each rising edge.
  always @(posedge clk) begin
    dtq_pkg::out_word_t exp_word;
    if (rst) begin
      timers.delete();
      expected_words.delete();
      capacity <= 5'd16;
      lease_held = '0;
      loose_tasks = 0;
      now_ms = '0;
      halted = 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (result_valid) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, result);
          fail_count <= fail_count + 1;
        end else begin
          exp_word = expected_words.pop_front();
          if (result !== exp_word) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_word, result);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) predict_command(cmd_in);
    end
    pending_count = expected_words.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer queue testbench
// Drives directed and random command words, with capacity changes between
// phases, into the deadline timer queue; the checker judges every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  dtq_pkg::in_word_t  cmd_in = '0;
  logic               busy;
  logic               cfg_we = 0;
  logic [4:0]         cfg_data = '0;
  logic               result_valid;
  dtq_pkg::out_word_t result;
  int                 fail_count;
  int                 pending_count;
  int                 cycle_count = 0;
  bit                 calm = 0;

  always #5 clk = ~clk;

  deadline_timer_queue_with_leases u_top (.*);

  dtq_checker u_checker (.*);

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Send one word; random idle gaps before it unless in a calm stretch.
  // The first edge keeps start low between the previous word and this one.
  task automatic send_word(logic [2:0] c, logic [31:0] d, logic [15:0] t,
                           logic [4:0] s);
    @(posedge clk);
    while (!calm && $urandom_range(99) < 13) @(posedge clk);
    start <= 1;
    cmd_in <= '{cmd: c, delay_ms: d, task_tag: t, lease_slot: s};
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 0;
  endtask

  task automatic wait_idle();
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_capacity(logic [4:0] v);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Random word mostly of useful commands with small delays and live slots.
  task automatic random_word();
    logic [2:0]  c;
    logic [31:0] d;
    logic [4:0]  s;
    int r;
    r = $urandom_range(99);
    if (r < 22) c = dtq_pkg::CMD_SCHEDULE;
    else if (r < 32) c = dtq_pkg::CMD_RESERVE;
    else if (r < 50) c = dtq_pkg::CMD_ARM;
    else if (r < 56) c = dtq_pkg::CMD_CANCEL;
    else if (r < 62) c = dtq_pkg::CMD_RELEASE;
    else if (r < 98) c = dtq_pkg::CMD_TICK;
    else c = dtq_pkg::CMD_UNUSED;
    d = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(12);
    s = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 4));
    send_word(c, d, 16'($urandom()), s);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: every command but stop, extreme delays and tags, bad slots.
    send_word(dtq_pkg::CMD_SCHEDULE, 32'hFFFF_FFFF, 16'hFFFF, 5'd0);
    send_word(dtq_pkg::CMD_SCHEDULE, 0, 16'h0000, 5'd31);
    send_word(dtq_pkg::CMD_SCHEDULE, 0, 16'hA5A5, 5'd0);
    send_word(dtq_pkg::CMD_RESERVE, 0, 0, 0);
    send_word(dtq_pkg::CMD_RESERVE, 0, 0, 0);
    send_word(dtq_pkg::CMD_ARM, 1, 16'h1234, 5'd1);
    send_word(dtq_pkg::CMD_ARM, 0, 16'h5678, 5'd1);
    send_word(dtq_pkg::CMD_ARM, 3, 16'h9ABC, 5'd0);
    send_word(dtq_pkg::CMD_ARM, 3, 16'h9ABC, 5'd17);
    send_word(dtq_pkg::CMD_ARM, 3, 16'h9ABC, 5'd5);
    send_word(dtq_pkg::CMD_CANCEL, 0, 0, 5'd2);
    send_word(dtq_pkg::CMD_TICK, 0, 0, 0);
    send_word(dtq_pkg::CMD_TICK, 0, 0, 0);
    send_word(dtq_pkg::CMD_RELEASE, 0, 0, 5'd2);
    send_word(dtq_pkg::CMD_RELEASE, 0, 0, 5'd2);
    send_word(dtq_pkg::CMD_UNUSED, 0, 0, 0);
    wait_idle();

    // Capacity zero refuses, then back to full.
    set_capacity(5'd0);
    send_word(dtq_pkg::CMD_SCHEDULE, 1, 1, 0);
    send_word(dtq_pkg::CMD_RESERVE, 0, 0, 0);
    wait_idle();
    set_capacity(5'd31);
    for (int i = 0; i < 18; i++) send_word(dtq_pkg::CMD_RESERVE, 0, 0, 0);
    wait_idle();
    set_capacity(5'd1);
    send_word(dtq_pkg::CMD_SCHEDULE, 0, 0, 0);
    for (int i = 1; i <= 16; i++) send_word(dtq_pkg::CMD_RELEASE, 0, 0, i[4:0]);
    wait_idle();

    // Random phases with several capacity settings.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_capacity(5'd16);
        1: set_capacity(5'd3);
        2: set_capacity(5'd8);
        3: set_capacity(5'd20);
        default: set_capacity(5'd1);
      endcase
      calm = (phase == 2);
      for (int i = 0; i < 90; i++) random_word();
      wait_idle();
    end
    calm = 0;

    // Fill the queue, then fire the due entries with one tick.
    set_capacity(5'd16);
    for (int i = 0; i < 16; i++) send_word(dtq_pkg::CMD_SCHEDULE, 1, i[15:0], 0);
    send_word(dtq_pkg::CMD_SCHEDULE, 1, 16'hBEEF, 0);
    send_word(dtq_pkg::CMD_TICK, 0, 0, 0);
    wait_idle();

    // Stop refuses everything afterwards.
    send_word(dtq_pkg::CMD_RESERVE, 0, 0, 0);
    send_word(dtq_pkg::CMD_SCHEDULE, 5, 7, 0);
    send_word(dtq_pkg::CMD_STOP, 0, 0, 0);
    send_word(dtq_pkg::CMD_STOP, 0, 0, 0);
    send_word(dtq_pkg::CMD_TICK, 0, 0, 0);
    send_word(dtq_pkg::CMD_CANCEL, 0, 0, 5'd1);
    send_word(dtq_pkg::CMD_RELEASE, 0, 0, 5'd1);
    send_word(dtq_pkg::CMD_SCHEDULE, 0, 0, 0);
    send_word(dtq_pkg::CMD_RESERVE, 0, 0, 0);

    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
